@@ rtl/bio_pkg.sv @@
`timescale 1ns / 1ps

package bio_pkg;

   // Default geometry: coordinate width and fraction bits of the ratio.
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 16;

   // Three stages of area arithmetic and one stage per quotient bit. The last
   // stage's registers drive the result ports, and the result is taken at the
   // edge that ends that cycle.
   function automatic int bio_latency(input int frac_bits);
      return frac_bits + 4;
   endfunction

endpackage

@@ rtl/bio_area.sv @@
`timescale 1ns / 1ps

module bio_area #(
   parameter int COORD_BITS = 12
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [COORD_BITS-1:0]   det_x,
   input  logic [COORD_BITS-1:0]   det_y,
   input  logic [COORD_BITS-1:0]   det_w,
   input  logic [COORD_BITS-1:0]   det_h,
   input  logic [COORD_BITS-1:0]   ref_x,
   input  logic [COORD_BITS-1:0]   ref_y,
   input  logic [COORD_BITS-1:0]   ref_w,
   input  logic [COORD_BITS-1:0]   ref_h,
   output logic                    out_valid,
   output logic [2*COORD_BITS:0]   overlap_area,
   output logic [2*COORD_BITS+1:0] joint_area
);

   localparam int EW = COORD_BITS + 1;
   localparam int AW = 2 * COORD_BITS + 1;
   localparam int JW = 2 * COORD_BITS + 2;

   // Length of the overlap of two inclusive spans, zero when they miss.
   function automatic logic [EW-1:0] span_len(input logic [COORD_BITS-1:0] a0,
                                              input logic [COORD_BITS-1:0] al,
                                              input logic [COORD_BITS-1:0] b0,
                                              input logic [COORD_BITS-1:0] bl);
      logic [EW-1:0] a1;
      logic [EW-1:0] b1;
      logic [EW-1:0] lo;
      logic [EW-1:0] hi;
      a1 = {1'b0, a0} + {1'b0, al};
      b1 = {1'b0, b0} + {1'b0, bl};
      lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
      hi = (a1 < b1) ? a1 : b1;
      if (hi >= lo) begin
         return hi - lo + EW'(1);
      end
      return '0;
   endfunction

   // Stage 1: overlap extents and inclusive box sizes.
   logic          s1_valid_ff, s1_valid_in;
   logic [EW-1:0] s1_ow_ff, s1_oh_ff;
   logic [EW-1:0] s1_dw_ff, s1_dh_ff, s1_rw_ff, s1_rh_ff;

   // Stage 2: the three areas.
   logic          s2_valid_ff;
   logic [AW-1:0] s2_inter_ff, s2_det_ff, s2_ref_ff;
   logic [2*EW-1:0] inter_prod, det_prod, ref_prod;

   // Stage 3: union area.
   logic          s3_valid_ff;
   logic [AW-1:0] s3_inter_ff;
   logic [JW-1:0] s3_joint_ff, s3_joint_in;

   assign s1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      s1_ow_ff <= span_len(det_x, det_w, ref_x, ref_w);
      s1_oh_ff <= span_len(det_y, det_h, ref_y, ref_h);
      s1_dw_ff <= {1'b0, det_w} + EW'(1);
      s1_dh_ff <= {1'b0, det_h} + EW'(1);
      s1_rw_ff <= {1'b0, ref_w} + EW'(1);
      s1_rh_ff <= {1'b0, ref_h} + EW'(1);
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // An empty extent in either axis already makes the product zero.
   assign inter_prod = s1_ow_ff * s1_oh_ff;
   assign det_prod   = s1_dw_ff * s1_dh_ff;
   assign ref_prod   = s1_rw_ff * s1_rh_ff;

   always_ff @(posedge clock) begin
      s2_inter_ff <= inter_prod[AW-1:0];
      s2_det_ff   <= det_prod[AW-1:0];
      s2_ref_ff   <= ref_prod[AW-1:0];
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   assign s3_joint_in = {1'b0, s2_det_ff} + {1'b0, s2_ref_ff} - {1'b0, s2_inter_ff};

   always_ff @(posedge clock) begin
      s3_inter_ff <= s2_inter_ff;
      s3_joint_ff <= s3_joint_in;
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   assign out_valid    = s3_valid_ff;
   assign overlap_area = s3_inter_ff;
   assign joint_area   = s3_joint_ff;

endmodule

@@ rtl/bio_div_step.sv @@
`timescale 1ns / 1ps

module bio_div_step #(
   parameter int  JW         = 26,
   parameter int  QW         = 17,
   parameter bit  FIRST_STEP = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [JW-1:0] in_rem,
   input  logic [JW-1:0] in_den,
   input  logic [QW-1:0] in_quot,
   input  logic [JW-2:0] in_inter,
   output logic          out_valid,
   output logic [JW-1:0] out_rem,
   output logic [JW-1:0] out_den,
   output logic [QW-1:0] out_quot,
   output logic [JW-2:0] out_inter
);

   logic          valid_ff;
   logic [JW-1:0] rem_ff, rem_in;
   logic [JW-1:0] den_ff;
   logic [QW-1:0] quot_ff, quot_in;
   logic [JW-2:0] inter_ff;
   logic [JW:0]   trial;
   logic [JW:0]   diff;
   logic          fits;

   // The first step tests the top quotient bit without doubling, since the
   // dividend starts no larger than the divisor.
   assign trial   = FIRST_STEP ? {1'b0, in_rem} : {in_rem, 1'b0};
   assign diff    = trial - {1'b0, in_den};
   assign fits    = (trial >= {1'b0, in_den});
   assign rem_in  = fits ? diff[JW-1:0] : trial[JW-1:0];
   assign quot_in = {in_quot[QW-2:0], fits};

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= in_den;
      quot_ff  <= quot_in;
      inter_ff <= in_inter;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quot  = quot_ff;
   assign out_inter = inter_ff;

endmodule

@@ rtl/box_intersection_over_union.sv @@
`timescale 1ns / 1ps

// Bounding-box intersection over union.
//
// A beat is accepted at each rising edge where start is high and busy is low.
// The beat carries a detection box and a ground-truth box, each as left,
// top, width and height, where a box spans width+1 by height+1 pixels.
// Busy is high only while reset is held, so one beat can enter every cycle.
// The result beat gives the overlap area, the union area and the ratio
// floor(overlap * 2^FRAC_BITS / union) with FRAC_BITS fraction bits.
// It is taken at the edge that ends its single cycle on the rsp_ ports,
// marked by rsp_valid.
// The divider resolves one quotient bit per pipeline stage; three stages of
// overlap, area and union arithmetic lead it.
// The receiver cannot stall the block, so the pipeline never holds a beat.
// A synchronous reset clears every valid bit and drops the beats in flight.
module box_intersection_over_union
   import bio_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [COORD_BITS-1:0]   req_det_x,
   input  logic [COORD_BITS-1:0]   req_det_y,
   input  logic [COORD_BITS-1:0]   req_det_w,
   input  logic [COORD_BITS-1:0]   req_det_h,
   input  logic [COORD_BITS-1:0]   req_ref_x,
   input  logic [COORD_BITS-1:0]   req_ref_y,
   input  logic [COORD_BITS-1:0]   req_ref_w,
   input  logic [COORD_BITS-1:0]   req_ref_h,
   output logic                    rsp_valid,
   output logic [2*COORD_BITS:0]   rsp_overlap_area,
   output logic [2*COORD_BITS+1:0] rsp_joint_area,
   output logic [FRAC_BITS:0]      rsp_iou_ratio
);

   localparam int JW    = 2 * COORD_BITS + 2;
   localparam int QW    = FRAC_BITS + 1;
   localparam int STEPS = FRAC_BITS + 1;

   logic          accept;
   logic          area_valid;
   logic [JW-2:0] area_inter;
   logic [JW-1:0] area_joint;

   // Divider chain: entry k feeds step k, entry STEPS is the last step's output.
   logic          dv_valid [0:STEPS];
   logic [JW-1:0] dv_rem   [0:STEPS];
   logic [JW-1:0] dv_den   [0:STEPS];
   logic [QW-1:0] dv_quot  [0:STEPS];
   logic [JW-2:0] dv_inter [0:STEPS];

   // The pipeline never backs up, so only reset holds off new beats.
   assign busy   = reset;
   assign accept = start & ~busy;

   bio_area #(
      .COORD_BITS(COORD_BITS)
   ) u_area (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .det_x       (req_det_x),
      .det_y       (req_det_y),
      .det_w       (req_det_w),
      .det_h       (req_det_h),
      .ref_x       (req_ref_x),
      .ref_y       (req_ref_y),
      .ref_w       (req_ref_w),
      .ref_h       (req_ref_h),
      .out_valid   (area_valid),
      .overlap_area(area_inter),
      .joint_area  (area_joint)
   );

   // The overlap never exceeds the union, so the quotient fits in FRAC_BITS+1
   // bits and the remainder starts as the overlap itself.
   assign dv_valid[0] = area_valid;
   assign dv_rem[0]   = {1'b0, area_inter};
   assign dv_den[0]   = area_joint;
   assign dv_quot[0]  = '0;
   assign dv_inter[0] = area_inter;

   for (genvar k = 0; k < STEPS; k++) begin : g_div
      bio_div_step #(
         .JW        (JW),
         .QW        (QW),
         .FIRST_STEP(k == 0)
      ) u_step (
         .clock    (clock),
         .reset    (reset),
         .in_valid (dv_valid[k]),
         .in_rem   (dv_rem[k]),
         .in_den   (dv_den[k]),
         .in_quot  (dv_quot[k]),
         .in_inter (dv_inter[k]),
         .out_valid(dv_valid[k+1]),
         .out_rem  (dv_rem[k+1]),
         .out_den  (dv_den[k+1]),
         .out_quot (dv_quot[k+1]),
         .out_inter(dv_inter[k+1])
      );
   end

   // The final remainder is not needed; the last step's registers are the
   // output registers.
   assign rsp_valid        = dv_valid[STEPS];
   assign rsp_overlap_area = dv_inter[STEPS];
   assign rsp_joint_area   = dv_den[STEPS];
   assign rsp_iou_ratio    = dv_quot[STEPS];

endmodule

@@ rtl/bio_checker.sv @@
`timescale 1ns / 1ps

module bio_checker
   import bio_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [2*COORD_BITS:0]   rsp_overlap_area,
   input logic [2*COORD_BITS+1:0] rsp_joint_area,
   input logic [FRAC_BITS:0]      rsp_iou_ratio
);

   localparam int LATENCY = bio_latency(FRAC_BITS);

   // Every accepted beat comes back after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted beat did not produce a result on time");

   // No result appears without a beat accepted the latency earlier.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a matching accepted beat");

   // The union covers the overlap and is never empty.
   a_union: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_joint_area != '0) &&
                    ({1'b0, rsp_overlap_area} <= rsp_joint_area))
      else $error("union area smaller than overlap or zero");

   // A ratio of one has an all-zero fraction, and it means the areas agree.
   a_unit_ratio: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_iou_ratio[FRAC_BITS]) |->
         (rsp_iou_ratio[FRAC_BITS-1:0] == '0) &&
         ({1'b0, rsp_overlap_area} == rsp_joint_area))
      else $error("ratio of one with unequal areas or nonzero fraction");

endmodule

bind box_intersection_over_union bio_checker #(
   .COORD_BITS(COORD_BITS),
   .FRAC_BITS (FRAC_BITS)
) u_bio_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_overlap_area(rsp_overlap_area),
   .rsp_joint_area  (rsp_joint_area),
   .rsp_iou_ratio   (rsp_iou_ratio)
);

@@ dv/box_iou_checker.sv @@
`timescale 1ns / 1ps

// Watches the request and response channels of the IoU block, predicts each
// response beat from the accepted request beat and compares field by field.
module box_iou_checker
   import bio_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    busy,
   input  logic [COORD_BITS-1:0]   req_det_x,
   input  logic [COORD_BITS-1:0]   req_det_y,
   input  logic [COORD_BITS-1:0]   req_det_w,
   input  logic [COORD_BITS-1:0]   req_det_h,
   input  logic [COORD_BITS-1:0]   req_ref_x,
   input  logic [COORD_BITS-1:0]   req_ref_y,
   input  logic [COORD_BITS-1:0]   req_ref_w,
   input  logic [COORD_BITS-1:0]   req_ref_h,
   input  logic                    rsp_valid,
   input  logic [2*COORD_BITS:0]   rsp_overlap_area,
   input  logic [2*COORD_BITS+1:0] rsp_joint_area,
   input  logic [FRAC_BITS:0]      rsp_iou_ratio,
   output int                      fail_count,
   output int                      pending_beats
);

   typedef struct {
      logic [2*COORD_BITS:0]   overlap_area;
      logic [2*COORD_BITS+1:0] joint_area;
      logic [FRAC_BITS:0]      iou_ratio;
   } iou_result_type;

   iou_result_type iou_expected_q[$];
   iou_result_type want;

   initial begin
      fail_count    = 0;
      pending_beats = 0;
   end

   task automatic report_error(input string msg);
      $display("%0t ns: ERROR %s", $time, msg);
      fail_count++;
   endtask

   // Length of the common part of the inclusive spans [a, a+alen] and [b, b+blen].
   function automatic longint span_common(input longint a, input longint alen,
                                          input longint b, input longint blen);
      longint lo;
      longint hi;
      lo = (a > b) ? a : b;
      hi = ((a + alen) < (b + blen)) ? (a + alen) : (b + blen);
      return (hi - lo + 1 > 0) ? (hi - lo + 1) : 0;
   endfunction

   function automatic iou_result_type predict_iou(
         input logic [COORD_BITS-1:0] dx, input logic [COORD_BITS-1:0] dy,
         input logic [COORD_BITS-1:0] dw, input logic [COORD_BITS-1:0] dh,
         input logic [COORD_BITS-1:0] gx, input logic [COORD_BITS-1:0] gy,
         input logic [COORD_BITS-1:0] gw, input logic [COORD_BITS-1:0] gh);
      longint ow;
      longint oh;
      longint inter;
      longint det_area;
      longint truth_area;
      longint joint;
      longint ratio;
      iou_result_type r;
      ow = span_common(longint'(dx), longint'(dw), longint'(gx), longint'(gw));
      oh = span_common(longint'(dy), longint'(dh), longint'(gy), longint'(gh));
      inter      = (ow == 0 || oh == 0) ? 0 : ow * oh;
      det_area   = (longint'(dw) + 1) * (longint'(dh) + 1);
      truth_area = (longint'(gw) + 1) * (longint'(gh) + 1);
      joint      = det_area + truth_area - inter;
      ratio      = (joint != 0) ? ((inter << FRAC_BITS) / joint) : 0;
      r.overlap_area = inter[2*COORD_BITS:0];
      r.joint_area   = joint[2*COORD_BITS+1:0];
      r.iou_ratio    = ratio[FRAC_BITS:0];
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (iou_expected_q.size() == 0) begin
               report_error($sformatf("response beat with nothing expected: overlap %0d",
                                      rsp_overlap_area));
            end else begin
               want = iou_expected_q.pop_front();
               if (rsp_overlap_area !== want.overlap_area)
                  report_error($sformatf("overlap_area expected %0d, got %0d",
                                         want.overlap_area, rsp_overlap_area));
               if (rsp_joint_area !== want.joint_area)
                  report_error($sformatf("joint_area expected %0d, got %0d",
                                         want.joint_area, rsp_joint_area));
               if (rsp_iou_ratio !== want.iou_ratio)
                  report_error($sformatf("iou_ratio expected %0d, got %0d",
                                         want.iou_ratio, rsp_iou_ratio));
            end
         end
         if (start && !busy)
            iou_expected_q.push_back(predict_iou(req_det_x, req_det_y, req_det_w, req_det_h,
                                                 req_ref_x, req_ref_y, req_ref_w, req_ref_h));
         pending_beats = iou_expected_q.size();
      end
   end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the box IoU block. The checker beside the block
// does all prediction and comparison; this module only drives request beats
// and decides pass or fail from the checker's counts.
module testbench;
   import bio_pkg::*;

   localparam int CB      = COORD_BITS_DEF;
   localparam int CMAX    = (1 << CB) - 1;
   localparam int LATENCY = bio_latency(FRAC_BITS_DEF);
   localparam int RANDOM_BEATS = 1800;

   typedef struct packed {
      logic [CB-1:0] x;
      logic [CB-1:0] y;
      logic [CB-1:0] w;
      logic [CB-1:0] h;
   } box_type;

   logic                    clock;
   logic                    reset;
   logic                    start;
   logic                    busy;
   logic [CB-1:0]           req_det_x;
   logic [CB-1:0]           req_det_y;
   logic [CB-1:0]           req_det_w;
   logic [CB-1:0]           req_det_h;
   logic [CB-1:0]           req_ref_x;
   logic [CB-1:0]           req_ref_y;
   logic [CB-1:0]           req_ref_w;
   logic [CB-1:0]           req_ref_h;
   logic                    rsp_valid;
   logic [2*CB:0]           rsp_overlap_area;
   logic [2*CB+1:0]         rsp_joint_area;
   logic [FRAC_BITS_DEF:0]  rsp_iou_ratio;
   int                      fail_count;
   int                      pending_beats;

   // Number of upcoming beats that go out back to back with no idle cycle.
   int                      burst_left;

   box_iou_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_det_x        (req_det_x),
      .req_det_y        (req_det_y),
      .req_det_w        (req_det_w),
      .req_det_h        (req_det_h),
      .req_ref_x        (req_ref_x),
      .req_ref_y        (req_ref_y),
      .req_ref_w        (req_ref_w),
      .req_ref_h        (req_ref_h),
      .rsp_valid        (rsp_valid),
      .rsp_overlap_area (rsp_overlap_area),
      .rsp_joint_area   (rsp_joint_area),
      .rsp_iou_ratio    (rsp_iou_ratio),
      .fail_count       (fail_count),
      .pending_beats    (pending_beats)
   );

   box_intersection_over_union dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_det_x        (req_det_x),
      .req_det_y        (req_det_y),
      .req_det_w        (req_det_w),
      .req_det_h        (req_det_h),
      .req_ref_x        (req_ref_x),
      .req_ref_y        (req_ref_y),
      .req_ref_w        (req_ref_w),
      .req_ref_h        (req_ref_h),
      .rsp_valid        (rsp_valid),
      .rsp_overlap_area (rsp_overlap_area),
      .rsp_joint_area   (rsp_joint_area),
      .rsp_iou_ratio    (rsp_iou_ratio)
   );

   // 10 ns clock, high half first.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog. The timeout lies well beyond the slowest correct run, so it only
   // trips when the simulation hangs.
   initial begin
      #2_000_000;
      $display("box_intersection_over_union verification failed");
      $finish;
   end

   function automatic box_type mk_box(input int x, input int y, input int w, input int h);
      box_type b;
      b.x = x[CB-1:0];
      b.y = y[CB-1:0];
      b.w = w[CB-1:0];
      b.h = h[CB-1:0];
      return b;
   endfunction

   // A coordinate within spread of base, clamped into the legal range.
   function automatic int near_coord(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0)
         v = 0;
      if (v > CMAX)
         v = CMAX;
      return v;
   endfunction

   // Presents one request beat at the falling edge and holds it until the
   // block takes it at a rising edge with busy low. Inputs only ever change
   // on falling edges, so the rising edge always sees settled values.
   task automatic send_pair(input box_type det, input box_type truth);
      @(negedge clock);
      start     <= 1'b1;
      req_det_x <= det.x;
      req_det_y <= det.y;
      req_det_w <= det.w;
      req_det_h <= det.h;
      req_ref_x <= truth.x;
      req_ref_y <= truth.y;
      req_ref_w <= truth.w;
      req_ref_h <= truth.h;
      do
         @(posedge clock);
      while (busy);
   endtask

   // Holds start low for a gap of length n. With n of zero nothing is touched, so the next
   // beat follows directly and start never sees two assignments in one step.
   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Random spacing after a beat: mostly none or a short gap, now and then a longer
   // gap that can outlast the pipeline, so that the bubbles land on every stage.
   // Bursts of back-to-back beats are mixed in to keep the pipeline full.
   task automatic random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (burst_left > 0) begin
         burst_left--;
      end else if (pick < 4) begin
         burst_left = $urandom_range(20, 60);
      end else if (pick < 60) begin
         idle_cycles(0);
      end else if (pick < 92) begin
         idle_cycles($urandom_range(1, 3));
      end else begin
         idle_cycles($urandom_range(8, 2 * LATENCY));
      end
   endtask

   // Holds start low until every predicted response beat has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_beats != 0)
         @(negedge clock);
   endtask

   // Builds one random box pair. Most pairs overlap, because the disjoint case
   // only exercises the zero clamp; the rest are fully random fields (which
   // toggle every input bit), boxes pushed against the edges of the range, and
   // identical or nearly identical pairs that drive the ratio toward one.
   task automatic random_pair(output box_type det, output box_type truth);
      int pick;
      int size_max;
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
         det   = mk_box($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                        $urandom_range(0, CMAX), $urandom_range(0, CMAX));
         truth = mk_box($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                        $urandom_range(0, CMAX), $urandom_range(0, CMAX));
      end else if (pick < 75) begin
         // Nearby boxes, small sizes most of the time, large ones sometimes.
         size_max = (pick < 60) ? 63 : CMAX;
         det   = mk_box($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                        $urandom_range(0, size_max), $urandom_range(0, size_max));
         truth = mk_box(near_coord(det.x, det.w + 8), near_coord(det.y, det.h + 8),
                        $urandom_range(0, size_max), $urandom_range(0, size_max));
      end else if (pick < 85) begin
         // Same or almost the same box.
         det   = mk_box($urandom_range(0, CMAX), $urandom_range(0, CMAX),
                        $urandom_range(0, 255), $urandom_range(0, 255));
         truth = mk_box(near_coord(det.x, 1), near_coord(det.y, 1),
                        near_coord(det.w, 1), near_coord(det.h, 1));
         if ($urandom_range(0, 1) == 0)
            truth = det;
      end else begin
         // Boxes against the low or high end of the coordinate range, where
         // right and bottom edges run past the coordinate width.
         det   = mk_box(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(CMAX - 15, CMAX),
                        ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(CMAX - 15, CMAX),
                        $urandom_range(0, CMAX), $urandom_range(0, CMAX));
         truth = mk_box(near_coord(det.x, 20), near_coord(det.y, 20),
                        $urandom_range(0, CMAX), $urandom_range(0, CMAX));
      end
   endtask

   initial begin
      box_type det;
      box_type truth;
      int      drain_wait;

      // Every input is known from time zero; reset is held at the start and released at a falling edge.
      reset      = 1'b1;
      start      = 1'b0;
      req_det_x  = '0;
      req_det_y  = '0;
      req_det_w  = '0;
      req_det_h  = '0;
      req_ref_x  = '0;
      req_ref_y  = '0;
      req_ref_w  = '0;
      req_ref_h  = '0;
      burst_left = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats, back to back.
      // Single-pixel boxes on the same pixel: the ratio is exactly one.
      send_pair(mk_box(0, 0, 0, 0), mk_box(0, 0, 0, 0));
      // Largest boxes at the far corner; both edges run far past the range.
      send_pair(mk_box(CMAX, CMAX, CMAX, CMAX), mk_box(CMAX, CMAX, CMAX, CMAX));
      // Full-range box against a single pixel in its far corner.
      send_pair(mk_box(0, 0, CMAX, CMAX), mk_box(CMAX, CMAX, 0, 0));
      // Full-range box against the largest box starting at its last pixel.
      send_pair(mk_box(0, 0, CMAX, CMAX), mk_box(CMAX, CMAX, CMAX, CMAX));
      // Same, but sharing only the last column.
      send_pair(mk_box(CMAX, 0, CMAX, CMAX), mk_box(0, 0, CMAX, CMAX));
      // Disjoint with a clear gap in x.
      send_pair(mk_box(0, 0, 10, 10), mk_box(20, 0, 10, 10));
      // Boxes that touch but share no column: overlap width is zero.
      send_pair(mk_box(0, 0, 9, 9), mk_box(10, 0, 9, 9));
      // Sharing exactly one column.
      send_pair(mk_box(0, 0, 9, 9), mk_box(9, 0, 9, 9));
      // Touching apart in y while overlapping in x.
      send_pair(mk_box(5, 0, 20, 9), mk_box(0, 10, 20, 9));
      // Overlapping in x, far apart in y.
      send_pair(mk_box(100, 100, 50, 50), mk_box(120, 3000, 50, 50));
      // Ground truth contained in the detection, and the other way round.
      send_pair(mk_box(100, 100, 200, 200), mk_box(150, 150, 20, 20));
      send_pair(mk_box(150, 150, 20, 20), mk_box(100, 100, 200, 200));
      // Ordinary partial overlap.
      send_pair(mk_box(1000, 2000, 300, 100), mk_box(1200, 2050, 300, 100));
      // Alternating bit patterns in every field.
      send_pair(mk_box('hAAA, 'h555, 'hAAA, 'h555), mk_box('h555, 'hAAA, 'h555, 'hAAA));
      send_pair(mk_box('h555, 'hAAA, 'h555, 'hAAA), mk_box('hAAA, 'h555, 'hAAA, 'h555));
      // Zero-size boxes far apart, and one width at maximum with zero height.
      send_pair(mk_box(CMAX, 0, 0, 0), mk_box(0, CMAX, 0, 0));
      send_pair(mk_box(0, 7, CMAX, 0), mk_box(7, 7, 0, CMAX));

      // Let the pipeline empty completely before the random part.
      hold_until_drained();

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         random_pair(det, truth);
         send_pair(det, truth);
         random_gap();
         if (i == RANDOM_BEATS / 2)
            hold_until_drained();
      end

      // Wait for the last response beats, with a bound, then watch a while
      // longer for stray beats.
      @(negedge clock);
      start <= 1'b0;
      drain_wait = 0;
      while (pending_beats != 0 && drain_wait < 20 * LATENCY) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (2 * LATENCY) @(posedge clock);

      if (fail_count == 0 && pending_beats == 0) begin
         $display("box_intersection_over_union verification clean");
      end else begin
         $display("box_intersection_over_union verification failed");
      end
      $finish;
   end

endmodule
